// ===== rtl/mfi_pkg.sv =====
`timescale 1ns / 1ps
// mfi_pkg: shared codes and constants of the isap max flow engine
// no dependencies
package mfi_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE     = 2'd1;
  localparam logic [1:0] CFG_SINK       = 2'd2;
  localparam logic [1:0] CFG_SPARE      = 2'd3;

  localparam logic [31:0] AUG_START = 32'h3f3f3f3f;

endpackage

// ===== rtl/mfi_in_if.sv =====
`timescale 1ns / 1ps
// mfi_in_if: input item channel of the isap max flow engine
// no dependencies
interface mfi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  from_node;
  logic [9:0]  to_node;
  logic [15:0] capacity;

  modport source (output valid, opcode, from_node, to_node, capacity, input ready);
  modport sink (input valid, opcode, from_node, to_node, capacity, output ready);
endinterface

// ===== rtl/mfi_out_if.sv =====
`timescale 1ns / 1ps
// mfi_out_if: result item channel of the isap max flow engine
// no dependencies
interface mfi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_total;
  logic        store_full;
  logic        was_run;

  modport source (output valid, flow_total, store_full, was_run, input ready);
  modport sink (input valid, flow_total, store_full, was_run, output ready);
endinterface

// ===== rtl/mfi_cfg_if.sv =====
`timescale 1ns / 1ps
// mfi_cfg_if: register write channel of the isap max flow engine
// no dependencies
interface mfi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [10:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/max_flow_isap.sv =====
`timescale 1ns / 1ps
// max_flow_isap: isap max flow engine with current-arc pointers and gap test
// depends on mfi_pkg, mfi_in_if, mfi_out_if, mfi_cfg_if

// One item at a time through a small sequencer around arc, node and label memories
// with a write port and a registered read port each. After reset the node lists
// and labels are swept clear before the first item is taken; a clear item costs
// the same sweep. An add-edge item takes four memory steps for the two list
// inserts. A run item first copies every list head into its current-arc pointer,
// then visits nodes and scans their arcs, walks the path back on each augment and
// rescans the arc list on each relabel, retreating to the predecessor unless it is
// at the source; its length depends on the graph. Configuration writes are taken
// at any time and must only be made while the engine is idle.
module max_flow_isap
  import mfi_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_ARCS  = 65536,
  parameter int CAP_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mfi_in_if.sink     in_ch,
  mfi_out_if.source  out_ch,
  mfi_cfg_if.sink    cfg_ch
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int NW = NB + 1;
  localparam int LW = NB + 2;
  localparam int AB = $clog2(MAX_ARCS);
  localparam logic [31:0] CAP_TOP = 32'hffffffff >> (32 - CAP_BITS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_E0, S_E1, S_E2, S_E3, S_COPY, S_TOP, S_TOP2, S_DU,
    S_SCAN, S_SCAN2, S_SCAN3, S_AUG1, S_AUG2, S_AUG3, S_AUG4,
    S_L1, S_L2, S_L3, S_L4, S_LEND, S_LT, S_LT2, S_LP, S_LP2, S_LP3, S_DONE
  } state_t;

  state_t state_r;

  logic [10:0]       node_count_r;
  logic [9:0]        source_r, sink_r;
  logic              item_r;
  logic [NW-1:0]     cnt_r, n_r, du_r, low_r, nl_r, steps_r;
  logic [AB:0]       arc_used_r;
  logic [NB-1:0]     a_r, b_r, s_r, t_r, u_r, v_r;
  logic [CAP_BITS-1:0] cap_r, r_r;
  logic [AB-1:0]     p_r, lk_r, e_r;
  logic [31:0]       aug_r, total_r;
  logic [31:0]       rsp_flow_r;
  logic              rsp_full_r, rsp_run_r;
  logic              out_valid_r;
  logic [31:0]       out_flow_r;
  logic              out_full_r, out_run_r;

  // memories
  logic [NB-1:0]       head_mem [MAX_ARCS];
  logic [CAP_BITS-1:0] res_mem  [MAX_ARCS];
  logic [AB-1:0]       link_mem [MAX_ARCS];
  logic [AB-1:0]       first_mem [MAX_NODES];
  logic [AB-1:0]       cur_mem  [MAX_NODES];
  logic [AB-1:0]       pred_mem [MAX_NODES];
  logic [31:0]         sb_mem   [MAX_NODES];
  logic [NW-1:0]       dist_mem [MAX_NODES];
  logic [NW-1:0]       tally_mem [MAX_NODES + 1];

  logic [NB-1:0]       head_rd_r;
  logic [CAP_BITS-1:0] res_rd_r;
  logic [AB-1:0]       link_rd_r, first_rd_r, cur_rd_r, pred_rd_r;
  logic [31:0]         sb_rd_r;
  logic [NW-1:0]       dist_rd_r, tally_rd_r;

  logic head_we, res_we, link_we, first_we, cur_we, pred_we, sb_we, dist_we, tally_we;
  logic [AB-1:0]       head_wa, res_wa, link_wa, head_ra, res_ra, link_ra;
  logic [NB-1:0]       head_wd;
  logic [CAP_BITS-1:0] res_wd;
  logic [AB-1:0]       link_wd, first_wd, cur_wd, pred_wd;
  logic [NB-1:0]       first_wa, first_ra, cur_wa, cur_ra, pred_wa, pred_ra;
  logic [NB-1:0]       sb_wa, sb_ra, dist_wa, dist_ra;
  logic [31:0]         sb_wd;
  logic [NW-1:0]       dist_wd, tally_wa, tally_ra, tally_wd;

  // datapath helpers
  logic [31:0]   nc32, n_eff32, cap32, aug_new;
  logic [32:0]   total_sum;
  logic [31:0]   total_sat;
  logic          add_bad, add_full, run_bad, admissible;
  logic [LW-1:0] lo1, d1, nl_max, nl_cap;
  logic [NW-1:0] tally_dec;
  logic [AB-1:0] k_arc;

  assign nc32    = 32'(node_count_r);
  assign n_eff32 = (nc32 < 32'd2) ? 32'd2 :
                   (nc32 > 32'(MAX_NODES)) ? 32'(MAX_NODES) : nc32;
  assign add_bad  = (32'(in_ch.from_node) >= 32'(MAX_NODES)) ||
                    (32'(in_ch.to_node) >= 32'(MAX_NODES));
  assign add_full = (32'(arc_used_r) + 32'd2) > 32'(MAX_ARCS);
  assign run_bad  = (32'(source_r) >= n_eff32) || (32'(sink_r) >= n_eff32);
  assign cap32    = (32'(in_ch.capacity) > CAP_TOP) ? CAP_TOP : 32'(in_ch.capacity);
  assign aug_new  = (32'(r_r) < aug_r) ? 32'(r_r) : aug_r;
  assign total_sum = {1'b0, total_r} + {1'b0, aug_new};
  assign total_sat = total_sum[32] ? 32'hffffffff : total_sum[31:0];
  assign admissible = (r_r != '0) && ((LW'(dist_rd_r) + LW'(1)) == LW'(du_r));
  assign lo1      = LW'(low_r) + LW'(1);
  assign d1       = LW'(du_r) + LW'(1);
  assign nl_max   = (lo1 > d1) ? lo1 : d1;
  assign nl_cap   = (nl_max > LW'(n_r)) ? LW'(n_r) : nl_max;
  assign tally_dec = tally_rd_r - NW'(1);
  assign k_arc    = AB'(arc_used_r);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.flow_total = out_flow_r;
  assign out_ch.store_full = out_full_r;
  assign out_ch.was_run    = out_run_r;

  always_comb begin
    head_we = 1'b0; res_we = 1'b0; link_we = 1'b0; first_we = 1'b0; cur_we = 1'b0;
    pred_we = 1'b0; sb_we = 1'b0; dist_we = 1'b0; tally_we = 1'b0;
    head_wa = '0; res_wa = '0; link_wa = '0; head_ra = '0; res_ra = '0; link_ra = '0;
    head_wd = '0; res_wd = '0; link_wd = '0; first_wd = '0; cur_wd = '0; pred_wd = '0;
    first_wa = '0; first_ra = '0; cur_wa = u_r; cur_ra = u_r; pred_wa = '0;
    pred_ra = u_r; sb_wa = u_r; sb_ra = '0; dist_wa = '0; dist_ra = '0; sb_wd = aug_r;
    dist_wd = '0; tally_wa = '0; tally_ra = '0; tally_wd = '0;
    unique case (state_r)
      S_CLR: begin
        first_we = (cnt_r < NW'(MAX_NODES));
        first_wa = NB'(cnt_r);
        dist_we  = first_we;
        dist_wa  = NB'(cnt_r);
        tally_we = 1'b1;
        tally_wa = cnt_r;
      end
      S_E0: first_ra = a_r;
      S_E1: begin
        link_we = 1'b1; link_wa = k_arc; link_wd = first_rd_r;
        head_we = 1'b1; head_wa = k_arc; head_wd = b_r;
        res_we  = 1'b1; res_wa  = k_arc; res_wd  = cap_r;
        first_we = 1'b1; first_wa = a_r; first_wd = k_arc;
      end
      S_E2: first_ra = b_r;
      S_E3: begin
        link_we = 1'b1; link_wa = k_arc + AB'(1); link_wd = first_rd_r;
        head_we = 1'b1; head_wa = k_arc + AB'(1); head_wd = a_r;
        res_we  = 1'b1; res_wa  = k_arc + AB'(1); res_wd  = '0;
        first_we = 1'b1; first_wa = b_r; first_wd = k_arc + AB'(1);
      end
      S_COPY: begin
        first_ra = NB'(cnt_r);
        cur_we   = (cnt_r != '0);
        cur_wa   = NB'(cnt_r - NW'(1));
        cur_wd   = first_rd_r;
        tally_we = (cnt_r == '0);
        tally_wa = '0;
        tally_wd = n_r;
      end
      S_TOP: begin
        dist_ra = s_r;
        sb_we   = 1'b1;
      end
      S_TOP2: dist_ra = u_r;
      S_SCAN: begin
        head_ra  = p_r; res_ra = p_r; link_ra = p_r;
        first_ra = u_r;
      end
      S_SCAN2: dist_ra = head_rd_r;
      S_SCAN3: begin
        cur_we  = admissible;
        cur_wd  = p_r;
        pred_we = admissible;
        pred_wa = v_r;
        pred_wd = p_r;
      end
      S_AUG2: res_ra = pred_rd_r;
      S_AUG3: begin
        res_we  = 1'b1;
        res_wa  = e_r;
        res_wd  = CAP_BITS'(32'(res_rd_r) - aug_r);
        res_ra  = e_r ^ AB'(1);
        head_ra = e_r ^ AB'(1);
      end
      S_AUG4: begin
        res_we = 1'b1;
        res_wa = e_r ^ AB'(1);
        res_wd = CAP_BITS'(32'(res_rd_r) + aug_r);
      end
      S_L2: begin
        head_ra = p_r; res_ra = p_r; link_ra = p_r;
      end
      S_L3: dist_ra = head_rd_r;
      S_L4: begin
        cur_we = (r_r != '0) && (dist_rd_r < low_r);
        cur_wd = p_r;
      end
      S_LEND: tally_ra = du_r;
      S_LT: begin
        tally_we = 1'b1;
        tally_wa = du_r;
        tally_wd = tally_dec;
        dist_we  = (tally_dec != '0);
        dist_wa  = u_r;
        dist_wd  = NW'(nl_cap);
        tally_ra = NW'(nl_cap);
      end
      S_LT2: begin
        tally_we = 1'b1;
        tally_wa = nl_r;
        tally_wd = tally_rd_r + NW'(1);
      end
      S_LP: head_ra = pred_rd_r ^ AB'(1);
      S_LP2: sb_ra = head_rd_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_r <= res_mem[res_ra];
  end
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[link_ra];
  end
  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    first_rd_r <= first_mem[first_ra];
  end
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd_r <= cur_mem[cur_ra];
  end
  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    pred_rd_r <= pred_mem[pred_ra];
  end
  always_ff @(posedge clk) begin
    if (sb_we) sb_mem[sb_wa] <= sb_wd;
    sb_rd_r <= sb_mem[sb_ra];
  end
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd_r <= dist_mem[dist_ra];
  end
  always_ff @(posedge clk) begin
    if (tally_we) tally_mem[tally_wa] <= tally_wd;
    tally_rd_r <= tally_mem[tally_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 11'd2;
      source_r     <= 10'd0;
      sink_r       <= 10'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_NODE_COUNT: node_count_r <= cfg_ch.data;
        CFG_SOURCE:     source_r     <= cfg_ch.data[9:0];
        CFG_SINK:       sink_r       <= cfg_ch.data[9:0];
        CFG_SPARE:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      item_r      <= 1'b0;
      arc_used_r  <= (AB + 1)'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + NW'(1);
          if (cnt_r == NW'(MAX_NODES)) begin
            arc_used_r <= (AB + 1)'(2);
            state_r    <= item_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r     <= 1'b1;
            rsp_flow_r <= '0;
            rsp_full_r <= 1'b0;
            rsp_run_r  <= 1'b0;
            cnt_r      <= '0;
            unique case (in_ch.opcode)
              OP_CLEAR: state_r <= S_CLR;
              OP_ADD: begin
                a_r   <= NB'(in_ch.from_node);
                b_r   <= NB'(in_ch.to_node);
                cap_r <= CAP_BITS'(cap32);
                if (add_bad) begin
                  state_r <= S_DONE;
                end else if (add_full) begin
                  rsp_full_r <= 1'b1;
                  state_r    <= S_DONE;
                end else begin
                  state_r <= S_E0;
                end
              end
              OP_RUN: begin
                rsp_run_r <= 1'b1;
                n_r       <= NW'(n_eff32);
                s_r       <= NB'(source_r);
                t_r       <= NB'(sink_r);
                u_r       <= NB'(source_r);
                aug_r     <= AUG_START;
                total_r   <= '0;
                state_r   <= run_bad ? S_DONE : S_COPY;
              end
              OP_NOP: state_r <= S_DONE;
            endcase
          end
        end
        S_E0: state_r <= S_E1;
        S_E1: state_r <= S_E2;
        S_E2: state_r <= S_E3;
        S_E3: begin
          arc_used_r <= arc_used_r + (AB + 1)'(2);
          state_r    <= S_DONE;
        end
        S_COPY: begin
          cnt_r <= cnt_r + NW'(1);
          if (cnt_r == NW'(MAX_NODES)) state_r <= S_TOP;
        end
        S_TOP: state_r <= S_TOP2;
        S_TOP2: begin
          if (dist_rd_r >= n_r) begin
            rsp_flow_r <= total_r;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_DU;
          end
        end
        S_DU: begin
          du_r    <= dist_rd_r;
          p_r     <= cur_rd_r;
          state_r <= S_SCAN;
        end
        S_SCAN: state_r <= (p_r == '0) ? S_L1 : S_SCAN2;
        S_SCAN2: begin
          v_r     <= head_rd_r;
          r_r     <= res_rd_r;
          lk_r    <= link_rd_r;
          state_r <= S_SCAN3;
        end
        S_SCAN3: begin
          if (admissible) begin
            aug_r <= aug_new;
            u_r   <= v_r;
            if (v_r == t_r) begin
              total_r <= total_sat;
              steps_r <= '0;
              state_r <= S_AUG1;
            end else begin
              state_r <= S_TOP;
            end
          end else begin
            p_r     <= lk_r;
            state_r <= S_SCAN;
          end
        end
        S_AUG1: begin
          if (u_r == s_r || steps_r == NW'(MAX_NODES)) begin
            u_r     <= s_r;
            aug_r   <= AUG_START;
            state_r <= S_TOP;
          end else begin
            state_r <= S_AUG2;
          end
        end
        S_AUG2: begin
          e_r     <= pred_rd_r;
          state_r <= S_AUG3;
        end
        S_AUG3: state_r <= S_AUG4;
        S_AUG4: begin
          u_r     <= head_rd_r;
          steps_r <= steps_r + NW'(1);
          state_r <= S_AUG1;
        end
        S_L1: begin
          p_r     <= first_rd_r;
          low_r   <= n_r - NW'(1);
          state_r <= S_L2;
        end
        S_L2: state_r <= (p_r == '0) ? S_LEND : S_L3;
        S_L3: begin
          r_r     <= res_rd_r;
          lk_r    <= link_rd_r;
          state_r <= S_L4;
        end
        S_L4: begin
          if (r_r != '0 && dist_rd_r < low_r) low_r <= dist_rd_r;
          p_r     <= lk_r;
          state_r <= S_L2;
        end
        S_LEND: state_r <= S_LT;
        S_LT: begin
          nl_r <= NW'(nl_cap);
          if (tally_dec == '0) begin
            rsp_flow_r <= total_r;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_LT2;
          end
        end
        S_LT2: state_r <= (u_r != s_r) ? S_LP : S_TOP;
        S_LP: state_r <= S_LP2;
        S_LP2: begin
          u_r     <= head_rd_r;
          state_r <= S_LP3;
        end
        S_LP3: begin
          aug_r   <= sb_rd_r;
          state_r <= S_TOP;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_flow_r  <= rsp_flow_r;
            out_full_r  <= rsp_full_r;
            out_run_r   <= rsp_run_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_arc_used_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    !arc_used_r[0] && arc_used_r >= (AB + 1)'(2) && 32'(arc_used_r) <= 32'(MAX_ARCS))
    else $error("arc fill count lost pair alignment");
  a_flow_only_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_run_r |-> out_flow_r == '0)
    else $error("flow reported for a non-run item");
  a_full_not_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_full_r && out_run_r))
    else $error("store full flagged on a run result");
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AUG4 |-> steps_r < NW'(MAX_NODES))
    else $error("augment walk exceeded node bound");
`endif

endmodule

// ===== tb/mfi_checker.sv =====
`timescale 1ns / 1ps
// mfi_checker: watches the item, result and register channels of max_flow_isap,
// predicts every result with its own isap max flow model and compares in order
// depends on mfi_pkg, mfi_in_if, mfi_out_if, mfi_cfg_if
module mfi_checker
  import mfi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mfi_in_if    in_ch,
  mfi_out_if   out_ch,
  mfi_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   runs_seen,
  output int   full_seen,
  output int   flow_seen
);
  localparam int NODES = 1024;
  localparam int ARCS  = 65536;

  typedef struct packed {
    logic [31:0] flow_total;
    logic        store_full;
    logic        was_run;
  } flow_result_t;

  flow_result_t expected_q[$];

  logic [9:0]  arc_to[ARCS];
  logic [15:0] arc_cap[ARCS];
  logic [15:0] arc_next[ARCS];
  int unsigned arcs_taken;
  logic [15:0] list_top[NODES];
  logic [15:0] cur_arc[NODES];
  logic [10:0] label[NODES];
  logic [10:0] label_cnt[NODES + 1];
  logic [15:0] came_by[NODES];
  logic [31:0] held_aug[NODES];
  logic [10:0] cfg_nodes;
  logic [9:0]  cfg_src;
  logic [9:0]  cfg_snk;

  function automatic void wipe_graph();
    arcs_taken = 2;
    foreach (list_top[i]) list_top[i] = '0;
    foreach (label[i]) label[i] = '0;
    foreach (label_cnt[i]) label_cnt[i] = '0;
  endfunction

  function automatic logic insert_edge(logic [9:0] a, logic [9:0] b, logic [15:0] c);
    int unsigned k;
    if (arcs_taken + 2 > ARCS) return 1'b1;
    k = arcs_taken;
    arc_next[k] = list_top[a]; arc_to[k] = b; arc_cap[k] = c;
    list_top[a] = 16'(k);
    arc_next[k + 1] = list_top[b]; arc_to[k + 1] = a; arc_cap[k + 1] = '0;
    list_top[b] = 16'(k + 1);
    arcs_taken = k + 2;
    return 1'b0;
  endfunction

  function automatic logic [31:0] max_flow();
    int unsigned n, s, t, u, v, p, e, low, nl, d, steps;
    logic [31:0] aug, total;
    bit found;
    total = '0;
    n = 32'(cfg_nodes);
    if (n < 2) n = 2;
    if (n > NODES) n = NODES;
    s = 32'(cfg_src); t = 32'(cfg_snk);
    if (s >= n || t >= n) return '0;
    label_cnt[0] = 11'(n);
    foreach (cur_arc[i]) cur_arc[i] = list_top[i];
    u = s; aug = AUG_START;
    while (label[s] < n) begin
      held_aug[u] = aug;
      found = 0;
      p = 32'(cur_arc[u]);
      while (p != 0 && !found) begin
        v = 32'(arc_to[p]);
        if (arc_cap[p] > 0 && int'(label[v]) + 1 == int'(label[u])) begin
          found = 1;
          cur_arc[u] = 16'(p);
          if (32'(arc_cap[p]) < aug) aug = 32'(arc_cap[p]);
          came_by[v] = 16'(p);
          u = v;
          if (u == t) begin
            total = (total > 32'hffffffff - aug) ? 32'hffffffff : total + aug;
            steps = 0;
            while (u != s && steps < NODES) begin
              e = 32'(came_by[u]);
              arc_cap[e] = 16'(32'(arc_cap[e]) - aug);
              arc_cap[e ^ 1] = 16'(32'(arc_cap[e ^ 1]) + aug);
              u = 32'(arc_to[e ^ 1]);
              steps++;
            end
            u = s;
            aug = AUG_START;
          end
        end else begin
          p = 32'(arc_next[p]);
        end
      end
      if (!found) begin
        low = n - 1;
        for (p = 32'(list_top[u]); p != 0; p = 32'(arc_next[p])) begin
          v = 32'(arc_to[p]);
          if (arc_cap[p] > 0 && 32'(label[v]) < low) begin
            cur_arc[u] = 16'(p);
            low = 32'(label[v]);
          end
        end
        d = 32'(label[u]);
        label_cnt[d] = label_cnt[d] - 11'd1;
        if (label_cnt[d] == 0) break;
        nl = low + 1;
        if (nl <= d) nl = d + 1;
        if (nl > n) nl = n;
        label[u] = 11'(nl);
        label_cnt[nl] = label_cnt[nl] + 11'd1;
        if (u != s) begin
          u = 32'(arc_to[came_by[u] ^ 16'd1]);
          aug = held_aug[u];
        end
      end
    end
    return total;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    flow_result_t want, got;
    if (!rst_n) begin
      expected_q.delete();
      wipe_graph();
      cfg_nodes <= 11'd2; cfg_src <= 10'd0; cfg_snk <= 10'd1;
      fail_count <= 0; runs_seen <= 0; full_seen <= 0; flow_seen <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_NODE_COUNT: cfg_nodes <= cfg_ch.data;
          CFG_SOURCE:     cfg_src <= cfg_ch.data[9:0];
          CFG_SINK:       cfg_snk <= cfg_ch.data[9:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = '0;
        case (in_ch.opcode)
          OP_CLEAR: wipe_graph();
          OP_ADD:   want.store_full = insert_edge(in_ch.from_node, in_ch.to_node,
                                                  in_ch.capacity);
          OP_RUN: begin
            want.flow_total = max_flow();
            want.was_run = 1'b1;
          end
          default: ;
        endcase
        expected_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.flow_total, out_ch.store_full, out_ch.was_run};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item flow=%0d full=%0b run=%0b", $time,
                   got.flow_total, got.store_full, got.was_run);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            $display({"%0t: mismatch expected flow=%0d full=%0b run=%0b,",
                      " got flow=%0d full=%0b run=%0b"},
                     $time, want.flow_total, want.store_full, want.was_run,
                     got.flow_total, got.store_full, got.was_run);
            fail_count <= fail_count + 1;
          end
          if (got.was_run) runs_seen <= runs_seen + 1;
          if (got.store_full) full_seen <= full_seen + 1;
          if (got.flow_total != 0) flow_seen <= flow_seen + 1;
        end
      end
    end
  end
endmodule

// ===== tb/tb_max_flow_isap.sv =====
`timescale 1ns / 1ps
// tb_max_flow_isap: drives graph items and register writes into max_flow_isap
// under random idling and a long result hold-off; verdict from mfi_checker
// depends on mfi_pkg, the mfi channel interfaces, max_flow_isap and mfi_checker
module tb_max_flow_isap;
  import mfi_pkg::*;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_go = 0;
  bit   hold_seen = 0;
  int   hold_left = 0;
  int   fail_count, pending, runs_seen, full_seen, flow_seen;

  mfi_in_if  in_ch();
  mfi_out_if out_ch();
  mfi_cfg_if cfg_ch();

  max_flow_isap uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                     .cfg_ch(cfg_ch));

  mfi_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                   .cfg_ch(cfg_ch), .fail_count(fail_count), .pending(pending),
                   .runs_seen(runs_seen), .full_seen(full_seen), .flow_seen(flow_seen));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_max_flow_isap: FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send(logic [1:0] op, logic [9:0] a, logic [9:0] b, logic [15:0] c);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op; in_ch.from_node <= a; in_ch.to_node <= b; in_ch.capacity <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic setup(int n, int s, int t);
    write_reg(CFG_NODE_COUNT, n[10:0]);
    write_reg(CFG_SOURCE, s[10:0]);
    write_reg(CFG_SINK, t[10:0]);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_cap();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_node(int n, int s, int t);
    int e;
    e = (n < 2) ? 2 : (n > 1024 ? 1024 : n);
    case ($urandom_range(5))
      0: return s[9:0];
      1: return t[9:0];
      default: return (e > 12 && $urandom_range(1)) ? 10'($urandom_range(e - 1))
                                                  : 10'($urandom_range((e > 12 ? 12 : e) - 1));
    endcase
  endfunction

  // mostly clean build-then-run sequences, some noise
  task automatic random_items(int count, int n, int s, int t);
    int done, m;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 40) begin
          send(OP_CLEAR, 10'($urandom), 10'($urandom), 16'($urandom));
          done++;
        end
        m = $urandom_range(1, 8);
        repeat (m) send(OP_ADD, pick_node(n, s, t), pick_node(n, s, t), pick_cap());
        send(OP_RUN, 10'($urandom), 10'($urandom), 16'($urandom));
        done += m + 1;
        if ($urandom_range(99) < 30) begin
          send(OP_RUN, '0, '0, '0);
          done++;
        end
      end else begin
        case ($urandom_range(2))
          0: send(OP_NOP, 10'($urandom), 10'($urandom), 16'($urandom));
          1: send(OP_ADD, 10'($urandom), 10'($urandom), 16'($urandom));
          default: send(OP_RUN, '0, '0, '0);
        endcase
        done++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.opcode = OP_NOP; in_ch.from_node = '0;
    in_ch.to_node = '0; in_ch.capacity = '0;
    cfg_ch.valid = 1'b0; cfg_ch.addr = CFG_NODE_COUNT; cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every opcode, gap, repeated run, terminals out of range
    send_idle = 6; recv_stall = 66;
    setup(4, 0, 3);
    send(OP_RUN, '0, '0, '0);
    send(OP_ADD, 10'd0, 10'd1, 16'hffff);
    send(OP_ADD, 10'd1, 10'd3, 16'd7);
    send(OP_ADD, 10'd0, 10'd2, 16'd5);
    send(OP_ADD, 10'd2, 10'd3, 16'hffff);
    send(OP_ADD, 10'd1, 10'd2, 16'd3);
    send(OP_ADD, 10'd3, 10'd0, 16'd0);
    send(OP_ADD, 10'd1023, 10'd0, 16'hffff);
    send(OP_ADD, 10'd0, 10'd1023, 16'd1);
    send(OP_RUN, '0, '0, '0);
    send(OP_RUN, '0, '0, '0);
    send(OP_ADD, 10'd0, 10'd3, 16'd9);
    send(OP_RUN, '0, '0, '0);
    send(OP_NOP, 10'h3ff, 10'h3ff, 16'hffff);
    send(OP_CLEAR, '0, '0, '0);
    send(OP_ADD, 10'd0, 10'd1, 16'd4);
    send(OP_RUN, '0, '0, '0);
    settle();
    setup(4, 6, 1);
    send(OP_ADD, 10'd1, 10'd3, 16'd2);
    send(OP_RUN, '0, '0, '0);
    settle();
    setup(0, 0, 1);
    send(OP_CLEAR, '0, '0, '0);
    send(OP_ADD, 10'd0, 10'd1, 16'd11);
    send(OP_RUN, '0, '0, '0);
    settle();

    setup(4, 0, 3);
    random_items(120, 4, 0, 3);
    settle();
    setup(16, 3, 9);
    random_items(120, 16, 3, 9);
    settle();

    send_idle = 66; recv_stall = 6;
    setup(2047, 0, 1023);
    send(OP_CLEAR, '0, '0, '0);
    random_items(60, 2047, 0, 1023);
    settle();
    setup(8, 7, 0);
    random_items(120, 8, 7, 0);
    settle();

    send_idle = 0; recv_stall = 0;
    setup(1024, 1023, 0);
    random_items(60, 1024, 1023, 0);
    settle();
    setup(12, 2, 11);
    random_items(120, 12, 2, 11);
    settle();

    // long result hold-off while items keep coming
    hold_go = ~hold_go;
    repeat (30) send(OP_ADD, 10'($urandom_range(11)), 10'($urandom_range(11)), pick_cap());
    send(OP_RUN, '0, '0, '0);
    settle();

    // fresh graph after a clear on the small setting
    setup(4, 0, 3);
    send(OP_CLEAR, '0, '0, '0);
    send(OP_ADD, 10'd0, 10'd3, 16'd5);
    send(OP_RUN, '0, '0, '0);
    settle();

    repeat (2200) @(posedge clk);
    $display("covered %0d runs (%0d with nonzero flow), %0d full-store answers,",
             runs_seen, flow_seen, full_seen);
    $display("register settings incl. node count extremes, bad terminals and a long hold-off");
    if (fail_count == 0) begin
      $display("tb_max_flow_isap: PASS");
    end else begin
      $display("tb_max_flow_isap: FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mfi_pkg.sv
rtl/mfi_in_if.sv
rtl/mfi_out_if.sv
rtl/mfi_cfg_if.sv
rtl/max_flow_isap.sv
tb/mfi_checker.sv
tb/tb_max_flow_isap.sv
